@@ src/wtim_pkg.sv @@
// ----------------------------------------------------------------------------
// wtim_pkg
// Shared types, constants and helpers for the wheel torque and imbalance unit.
// ----------------------------------------------------------------------------
package wtim_pkg;

  localparam int NPAR = 15;

  localparam logic signed [63:0] ONE30   = 64'sd1073741824;
  localparam logic signed [63:0] CLAMP62 = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] C_A1    = 64'sd1686629713;
  localparam logic signed [63:0] C_A3    = 64'sd693598668;
  localparam logic signed [63:0] C_A5    = 64'sd85569306;
  localparam logic signed [63:0] C_A7    = 64'sd5026996;
  localparam logic signed [63:0] C_A9    = 64'sd172272;

  localparam logic signed [65:0] MAX48 = 66'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] MIN48 = -66'sh0_0000_8000_0000_0000;

  // Right shift applied after a product
  typedef enum logic [1:0] {
    SH0,
    SH24,
    SH30,
    SH32
  } shift_t;

  typedef struct packed {
    logic   start;
    shift_t sh;
  } mul_req_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > MAX48) begin
      r = MAX48[47:0];
    end else if (v < MIN48) begin
      r = MIN48[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

@@ src/wtim_ram.sv @@
// ----------------------------------------------------------------------------
// wtim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wtim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/wtim_mul.sv @@
// ----------------------------------------------------------------------------
// wtim_mul
// Signed 64x64 multiply with floor shift and clamp to magnitude 2^62.
// One 32x32 partial product per cycle, then shift and round/clamp stages.
// ----------------------------------------------------------------------------
module wtim_mul
  import wtim_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_PP,
    M_SH,
    M_FIN
  } mstate_t;

  mstate_t      state;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  shift_t       sh;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         ovf;
  logic [63:0]  qlo;
  logic         rem;

  logic [31:0]  half_a;
  logic [31:0]  half_b;
  logic [63:0]  pp;
  logic [1:0]   hsum;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic         rem_c;
  logic [63:0]  v;

  always_comb begin
    half_a = cnt[1] ? ua[63:32] : ua[31:0];
    half_b = cnt[0] ? ub[63:32] : ub[31:0];
    pp     = 64'(half_a) * 64'(half_b);
    hsum   = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    pp_sh  = {64'b0, pp} << {hsum, 5'b0};
  end

  always_comb begin
    case (sh)
      SH0: begin
        q     = acc;
        rem_c = 1'b0;
      end
      SH24: begin
        q     = acc >> 24;
        rem_c = |acc[23:0];
      end
      SH30: begin
        q     = acc >> 30;
        rem_c = |acc[29:0];
      end
      SH32: begin
        q     = acc >> 32;
        rem_c = |acc[31:0];
      end
      default: begin
        q     = acc;
        rem_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ovf) begin
      v = CLAMP62;
    end else begin
      v = qlo + {63'b0, neg & rem};
    end
    if (v > CLAMP62) begin
      v = CLAMP62;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            ua    <= a[63] ? 64'(-a) : 64'(a);
            ub    <= b[63] ? 64'(-b) : 64'(b);
            neg   <= a[63] ^ b[63];
            sh    <= req.sh;
            acc   <= '0;
            cnt   <= '0;
            state <= M_PP;
          end
        end
        M_PP: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= M_SH;
          end
        end
        M_SH: begin
          ovf   <= (q[127:64] != '0) || (q[63:0] > CLAMP62);
          qlo   <= q[63:0];
          rem   <= rem_c;
          state <= M_FIN;
        end
        M_FIN: begin
          res   <= neg ? -$signed(v) : $signed(v);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

@@ src/wheel_torque_and_imbalance_model_unit.sv @@
// ----------------------------------------------------------------------------
// wheel_torque_and_imbalance_model_unit
// Reaction wheel torque limit/deadband/friction and static/dynamic imbalance.
// ----------------------------------------------------------------------------
// Load beat: written to the RAM as it is taken; the next beat can be taken the following cycle.
// Command beat: the wheel's parameter words are read from the RAM, then the torque
// logic runs; with jitter off out_valid then rises. With jitter on, 33 products run
// one after another through the shared 64x64 multiplier before out_valid rises.
// One item at a time; the next beat is taken the cycle after the last result.
// Reset clears control state and the pass sums; the parameter RAM is not reset.
module wheel_torque_and_imbalance_model_unit
  import wtim_pkg::*;
#(
  parameter int MAX_WHEELS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [3:0]         wheel_index,
  input  logic [3:0]         param_select,
  input  logic signed [31:0] param_value,
  input  logic signed [31:0] torque_cmd,
  input  logic signed [31:0] wheel_speed,
  input  logic [15:0]        wheel_angle,
  input  logic               last_wheel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_wheel,
  output logic               is_total,
  output logic signed [31:0] motor_torque,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic signed [47:0] jitter_torque_x,
  output logic signed [47:0] jitter_torque_y,
  output logic signed [47:0] jitter_torque_z,
  output logic               last_of_run
);

  localparam int DEPTH = MAX_WHEELS * NPAR;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [5:0] ST_LAST   = 6'd32;
  localparam logic [5:0] ST_SINE_B = 6'd6;
  localparam logic [3:0] SEL_LAST  = 4'd14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_TORQ,
    S_ISSUE,
    S_WAIT,
    S_SUM,
    S_OUT1,
    S_OUT2
  } state_t;

  state_t             state;
  logic [3:0]         wheel;
  logic signed [31:0] tcmd;
  logic signed [31:0] omega;
  logic [15:0]        angle;
  logic               last;
  logic               wok;
  logic [7:0]         base;
  logic [3:0]         rcnt;
  logic signed [31:0] prm [NPAR];
  logic signed [31:0] mtq;
  logic [5:0]         step;

  logic signed [63:0] x2;
  logic signed [63:0] t;
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic signed [63:0] w2;
  logic signed [63:0] ks;
  logic signed [63:0] kd;
  logic signed [63:0] g [3];
  logic signed [47:0] fo [3];
  logic signed [47:0] to [3];
  logic signed [65:0] acc;
  logic signed [47:0] sum_f [3];
  logic signed [47:0] sum_t [3];

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              in_fire;
  logic              w_ok_in;
  logic [7:0]        base_in;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign w_ok_in   = (32'(wheel_index) < MAX_WHEELS);
  assign base_in   = {wheel_index, 4'b0} - {4'b0, wheel_index};
  assign ram_we    = in_fire && !req_type && (param_select <= SEL_LAST) && w_ok_in;
  assign ram_waddr = AW'(base_in + {4'b0, param_select});
  assign ram_raddr = AW'(base) + AW'(rcnt);

  wtim_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (param_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Torque limit, deadband, friction
  logic signed [33:0] lim;
  logic signed [33:0] dead;
  logic signed [33:0] fric;
  logic signed [33:0] u1;
  logic signed [33:0] u2;
  logic signed [33:0] u3;
  logic signed [33:0] absu;
  logic signed [33:0] absu2;
  logic signed [31:0] u_sat;

  always_comb begin
    lim  = 34'(prm[0]);
    dead = 34'(prm[1]);
    fric = 34'(prm[2]);
    u1   = 34'(tcmd);
    if (lim > 0) begin
      if (u1 > lim) begin
        u1 = lim;
      end else if (u1 < -lim) begin
        u1 = -lim;
      end
    end
    absu = (u1 < 0) ? -u1 : u1;
    u2   = (absu < dead) ? 34'sd0 : u1;
    absu2 = (u2 < 0) ? -u2 : u2;
    if (omega > 0) begin
      u3 = u2 - fric;
    end else if (omega < 0) begin
      u3 = u2 + fric;
    end else if (absu2 < fric) begin
      u3 = 34'sd0;
    end else begin
      u3 = u2;
    end
    if (u3 > 34'sd2147483647) begin
      u_sat = 32'sh7FFF_FFFF;
    end else if (u3 < -34'sd2147483648) begin
      u_sat = 32'sh8000_0000;
    end else begin
      u_sat = u3[31:0];
    end
  end

  // Angle, sine argument and quadrant mapping
  logic [23:0]        ang24;
  logic [31:0]        p;
  logic signed [63:0] xarg;
  logic signed [31:0] sn;
  logic signed [31:0] cs;

  always_comb begin
    ang24 = 24'(angle);
    p     = {ang24[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    xarg  = (step < ST_SINE_B) ? $signed({34'b0, p[29:0]}) :
                                 ONE30 - $signed({34'b0, p[29:0]});
    case (p[31:30])
      2'd0: begin
        sn = sa;
        cs = sb;
      end
      2'd1: begin
        sn = sb;
        cs = -sa;
      end
      2'd2: begin
        sn = -sa;
        cs = -sb;
      end
      default: begin
        sn = -sb;
        cs = sa;
      end
    endcase
  end

  // Multiplier operand schedule
  mul_req_t           mreq;
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic               mdone;
  logic signed [63:0] mres;

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mreq.sh = SH30;
    case (step)
      6'd0, 6'd6: begin
        op_a = xarg;
        op_b = xarg;
      end
      6'd1, 6'd7: begin
        op_a = C_A9;
        op_b = x2;
      end
      6'd2, 6'd3, 6'd4, 6'd8, 6'd9, 6'd10: begin
        op_a = t;
        op_b = x2;
      end
      6'd5, 6'd11: begin
        op_a = t;
        op_b = xarg;
      end
      6'd12: begin
        op_a    = 64'(omega);
        op_b    = 64'(omega);
        mreq.sh = SH0;
      end
      6'd13: begin
        op_a    = 64'(prm[3]);
        op_b    = w2;
        mreq.sh = SH32;
      end
      6'd14: begin
        op_a    = 64'(prm[4]);
        op_b    = w2;
        mreq.sh = SH32;
      end
      6'd15: begin
        op_a = 64'(cs);
        op_b = 64'(prm[5]);
      end
      6'd16: begin
        op_a = 64'(sn);
        op_b = 64'(prm[8]);
      end
      6'd17: begin
        op_a = 64'(cs);
        op_b = 64'(prm[6]);
      end
      6'd18: begin
        op_a = 64'(sn);
        op_b = 64'(prm[9]);
      end
      6'd19: begin
        op_a = 64'(cs);
        op_b = 64'(prm[7]);
      end
      6'd20: begin
        op_a = 64'(sn);
        op_b = 64'(prm[10]);
      end
      6'd21: begin
        op_a = ks;
        op_b = g[0];
      end
      6'd22: begin
        op_a = ks;
        op_b = g[1];
      end
      6'd23: begin
        op_a = ks;
        op_b = g[2];
      end
      // tau_x = ry*Fz - rz*Fy + kd*gx
      6'd24: begin
        op_a    = 64'(prm[12]);
        op_b    = 64'(fo[2]);
        mreq.sh = SH24;
      end
      6'd25: begin
        op_a    = 64'(prm[13]);
        op_b    = 64'(fo[1]);
        mreq.sh = SH24;
      end
      6'd26: begin
        op_a = kd;
        op_b = g[0];
      end
      // tau_y = rz*Fx - rx*Fz + kd*gy
      6'd27: begin
        op_a    = 64'(prm[13]);
        op_b    = 64'(fo[0]);
        mreq.sh = SH24;
      end
      6'd28: begin
        op_a    = 64'(prm[11]);
        op_b    = 64'(fo[2]);
        mreq.sh = SH24;
      end
      6'd29: begin
        op_a = kd;
        op_b = g[1];
      end
      // tau_z = rx*Fy - ry*Fx + kd*gz
      6'd30: begin
        op_a    = 64'(prm[11]);
        op_b    = 64'(fo[1]);
        mreq.sh = SH24;
      end
      6'd31: begin
        op_a    = 64'(prm[12]);
        op_b    = 64'(fo[0]);
        mreq.sh = SH24;
      end
      6'd32: begin
        op_a = kd;
        op_b = g[2];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mreq.start = (state == S_ISSUE);
  end

  wtim_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (op_a),
    .b    (op_b),
    .done (mdone),
    .res  (mres)
  );

  // Quarter-sine result clamped to [0, 1.0]
  logic signed [31:0] sclamp;
  always_comb begin
    if (mres < 0) begin
      sclamp = '0;
    end else if (mres > ONE30) begin
      sclamp = ONE30[31:0];
    end else begin
      sclamp = mres[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        sum_f[i] <= '0;
        sum_t[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && req_type) begin
            wheel <= wheel_index;
            tcmd  <= torque_cmd;
            omega <= wheel_speed;
            angle <= wheel_angle;
            last  <= last_wheel;
            wok   <= w_ok_in;
            base  <= base_in;
            rcnt  <= '0;
            for (int i = 0; i < 3; i++) begin
              fo[i] <= '0;
              to[i] <= '0;
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          rcnt <= rcnt + 4'd1;
          if (rcnt != 4'd0) begin
            prm[4'(rcnt - 4'd1)] <= wok ? $signed(ram_rdata) : 32'sd0;
          end
          if (rcnt == 4'd15) begin
            state <= S_TORQ;
          end
        end
        S_TORQ: begin
          mtq  <= u_sat;
          step <= '0;
          state <= (prm[14] != 0) ? S_ISSUE : S_OUT1;
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mdone) begin
            case (step)
              6'd0, 6'd6: x2 <= mres;
              6'd1, 6'd7: t <= C_A7 - mres;
              6'd2, 6'd8: t <= C_A5 - mres;
              6'd3, 6'd9: t <= C_A3 - mres;
              6'd4, 6'd10: t <= C_A1 - mres;
              6'd5: sa <= sclamp;
              6'd11: sb <= sclamp;
              6'd12: w2 <= mres;
              6'd13: ks <= mres;
              6'd14: kd <= mres;
              6'd15: g[0] <= mres;
              6'd16: g[0] <= g[0] + mres;
              6'd17: g[1] <= mres;
              6'd18: g[1] <= g[1] + mres;
              6'd19: g[2] <= mres;
              6'd20: g[2] <= g[2] + mres;
              6'd21: fo[0] <= sat48(66'(mres));
              6'd22: fo[1] <= sat48(66'(mres));
              6'd23: fo[2] <= sat48(66'(mres));
              6'd24, 6'd27, 6'd30: acc <= 66'(mres);
              6'd25, 6'd28, 6'd31: acc <= acc - 66'(mres);
              6'd26: to[0] <= sat48(acc + 66'(mres));
              6'd29: to[1] <= sat48(acc + 66'(mres));
              6'd32: to[2] <= sat48(acc + 66'(mres));
              default: acc <= acc;
            endcase
            if (step == ST_LAST) begin
              state <= S_SUM;
            end else begin
              step  <= step + 6'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_SUM: begin
          for (int i = 0; i < 3; i++) begin
            sum_f[i] <= sat48(66'(sum_f[i]) + 66'(fo[i]));
            sum_t[i] <= sat48(66'(sum_t[i]) + 66'(to[i]));
          end
          state <= S_OUT1;
        end
        S_OUT1: begin
          if (out_ready) begin
            state <= last ? S_OUT2 : S_IDLE;
          end
        end
        S_OUT2: begin
          if (out_ready) begin
            // drop the pass sums once the totals beat is taken
            for (int i = 0; i < 3; i++) begin
              sum_f[i] <= '0;
              sum_t[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state == S_OUT1) || (state == S_OUT2);
  assign is_total        = (state == S_OUT2);
  assign out_wheel       = is_total ? 4'd0 : wheel;
  assign motor_torque    = is_total ? 32'sd0 : mtq;
  assign force_x         = is_total ? sum_f[0] : fo[0];
  assign force_y         = is_total ? sum_f[1] : fo[1];
  assign force_z         = is_total ? sum_f[2] : fo[2];
  assign jitter_torque_x = is_total ? sum_t[0] : to[0];
  assign jitter_torque_y = is_total ? sum_t[1] : to[1];
  assign jitter_torque_z = is_total ? sum_t[2] : to[2];
  assign last_of_run     = is_total || !last;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_total) |-> last_of_run)
    else $error("totals beat not marked last");

  a_total_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !is_total && !last_of_run) |=> (out_valid && is_total))
    else $error("totals beat missing after last wheel");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && is_total) |=>
      (sum_f[0] == 0 && sum_f[1] == 0 && sum_f[2] == 0 &&
       sum_t[0] == 0 && sum_t[1] == 0 && sum_t[2] == 0))
    else $error("pass sums not cleared after totals");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reaction wheel torque and imbalance unit. Loads
// the per-wheel tables, drives directed and random commands with random gaps
// on both handshakes, predicts every wheel and totals beat and compares them
// in order.
// ----------------------------------------------------------------------------
module testbench
  import wtim_pkg::*;
();

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CMD  = 1'b1;
  localparam int SEL_LIMIT = 0, SEL_DEAD = 1, SEL_FRIC = 2, SEL_US = 3, SEL_UD = 4;
  localparam int SEL_G0 = 5, SEL_H0 = 8, SEL_POS = 11, SEL_JIT = 14, SEL_NONE = 15;
  localparam int WHEELS = 16;

  typedef struct packed {
    logic        kind;
    logic [3:0]  wheel;
    logic [3:0]  sel;
    logic [31:0] value;
    logic [31:0] torque;
    logic [31:0] speed;
    logic [15:0] angle;
    logic        last;
  } wheel_req_t;

  typedef struct packed {
    logic [3:0]  wheel;
    logic        tot;
    logic [31:0] mt;
    logic [47:0] fx, fy, fz, tx, ty, tz;
    logic        last;
  } wheel_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic req_type = 0, last_wheel = 0;
  logic [3:0] wheel_index = 0, param_select = 0;
  logic signed [31:0] param_value = 0, torque_cmd = 0, wheel_speed = 0;
  logic [15:0] wheel_angle = 0;
  logic [3:0] out_wheel;
  logic is_total, last_of_run;
  logic signed [31:0] motor_torque;
  logic signed [47:0] force_x, force_y, force_z;
  logic signed [47:0] jitter_torque_x, jitter_torque_y, jitter_torque_z;

  wheel_torque_and_imbalance_model_unit dut (.*);

  always #5 clk = ~clk;

  int         wheel_tbl[WHEELS][15];
  longint     pass_force[3], pass_torque[3];
  wheel_res_t pending_q[$];
  int         mismatches = 0;
  bit         hold_out = 0;

  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] pa, pb, p, lim;
    pa = a; pb = b; lim = 1; lim = lim <<< 62;
    p = (pa * pb) >>> s;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p[63:0];
  endfunction

  function automatic longint clip48(logic signed [67:0] v);
    if (v > 68'sh0_7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -68'sh0_8000_0000_0000) return -64'sh8000_0000_0000;
    return v[63:0];
  endfunction

  function automatic longint quarter_sin(longint x);
    longint x2, t;
    x2 = mul_floor(x, x, 30);
    t = C_A9;
    t = C_A7 - mul_floor(t, x2, 30);
    t = C_A5 - mul_floor(t, x2, 30);
    t = C_A3 - mul_floor(t, x2, 30);
    t = C_A1 - mul_floor(t, x2, 30);
    t = mul_floor(t, x, 30);
    return t < 0 ? 0 : (t > ONE30 ? ONE30 : t);
  endfunction

  // Work out the beats one accepted item causes and queue them.
  function automatic void predict_wheel(wheel_req_t r);
    longint u, au, lim, dead, fric, om, a, b, sn, cs, w2, ks, kd;
    longint g[3], rv[3], fv[3], tv[3];
    logic [31:0] ph;
    wheel_res_t e;
    int j, k;
    if (r.kind == REQ_LOAD) begin
      if (r.sel != SEL_NONE) wheel_tbl[r.wheel][r.sel] = r.value;
      return;
    end
    u = $signed(r.torque); om = $signed(r.speed);
    lim = wheel_tbl[r.wheel][SEL_LIMIT];
    dead = wheel_tbl[r.wheel][SEL_DEAD];
    fric = wheel_tbl[r.wheel][SEL_FRIC];
    if (lim > 0) begin
      if (u > lim) u = lim;
      else if (u < -lim) u = -lim;
    end
    au = u < 0 ? -u : u;
    if (au < dead) u = 0;
    au = u < 0 ? -u : u;
    if (om > 0) u -= fric;
    else if (om < 0) u += fric;
    else if (au < fric) u = 0;
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    for (int i = 0; i < 3; i++) begin fv[i] = 0; tv[i] = 0; end
    if (wheel_tbl[r.wheel][SEL_JIT] != 0) begin
      ph = {r.angle, 16'h0};
      a = quarter_sin(64'(ph[29:0]));
      b = quarter_sin(ONE30 - 64'(ph[29:0]));
      case (ph[31:30])
        2'd0: begin sn = a;  cs = b;  end
        2'd1: begin sn = b;  cs = -a; end
        2'd2: begin sn = -a; cs = -b; end
        default: begin sn = -b; cs = a; end
      endcase
      w2 = om * om;
      ks = mul_floor(wheel_tbl[r.wheel][SEL_US], w2, 32);
      kd = mul_floor(wheel_tbl[r.wheel][SEL_UD], w2, 32);
      for (int i = 0; i < 3; i++) begin
        g[i] = mul_floor(cs, wheel_tbl[r.wheel][SEL_G0 + i], 30)
             + mul_floor(sn, wheel_tbl[r.wheel][SEL_H0 + i], 30);
        rv[i] = wheel_tbl[r.wheel][SEL_POS + i];
        fv[i] = clip48(mul_floor(ks, g[i], 30));
      end
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3; k = (i + 2) % 3;
        tv[i] = clip48(68'(mul_floor(rv[j], fv[k], 24)) - 68'(mul_floor(rv[k], fv[j], 24))
                       + 68'(mul_floor(kd, g[i], 30)));
        pass_force[i] = clip48(68'(pass_force[i]) + 68'(fv[i]));
        pass_torque[i] = clip48(68'(pass_torque[i]) + 68'(tv[i]));
      end
    end
    e = '{r.wheel, 1'b0, u[31:0], fv[0][47:0], fv[1][47:0], fv[2][47:0],
          tv[0][47:0], tv[1][47:0], tv[2][47:0], !r.last};
    pending_q.push_back(e);
    if (r.last) begin
      e = '{4'd0, 1'b1, 32'd0, pass_force[0][47:0], pass_force[1][47:0],
            pass_force[2][47:0], pass_torque[0][47:0], pass_torque[1][47:0],
            pass_torque[2][47:0], 1'b1};
      pending_q.push_back(e);
      for (int i = 0; i < 3; i++) begin pass_force[i] = 0; pass_torque[i] = 0; end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(wheel_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= r.kind; wheel_index <= r.wheel; param_select <= r.sel;
    param_value <= r.value; torque_cmd <= r.torque; wheel_speed <= r.speed;
    wheel_angle <= r.angle; last_wheel <= r.last;
    do @(posedge clk); while (!in_ready);
    predict_wheel(r);
  endtask

  function automatic logic [31:0] rand_param(int sel);
    if ($urandom_range(0, 7) == 0) return $urandom;
    case (sel)
      SEL_LIMIT: return $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 1 << 26);
      SEL_DEAD, SEL_FRIC: return $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 1 << 22);
      SEL_US, SEL_UD: return $urandom_range(0, 1 << 21) - (1 << 20);
      SEL_POS, SEL_POS + 1, SEL_POS + 2: return $urandom_range(0, 1 << 25) - (1 << 24);
      SEL_JIT: return $urandom_range(0, 3) == 0 ? 0 : $urandom;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  function automatic wheel_req_t rand_command();
    wheel_req_t r;
    r = '0;
    r.kind = REQ_CMD;
    r.wheel = 4'($urandom_range(0, WHEELS - 1));
    r.sel = 4'($urandom);
    r.value = $urandom;
    case ($urandom_range(0, 5))
      0: r.torque = $urandom;
      1: r.torque = 0;
      default: r.torque = $urandom_range(0, 1 << 27) - (1 << 26);
    endcase
    case ($urandom_range(0, 5))
      0: r.speed = $urandom;
      1: r.speed = 0;
      default: r.speed = $urandom_range(0, 1 << 26) - (1 << 25);
    endcase
    r.angle = 16'($urandom);
    r.last = $urandom_range(0, 5) == 0;
    return r;
  endfunction

  function automatic wheel_req_t load_req(int w, int sel, logic [31:0] v);
    wheel_req_t r;
    r = '0;
    r.kind = REQ_LOAD; r.wheel = 4'(w); r.sel = 4'(sel); r.value = v;
    r.torque = $urandom; r.speed = $urandom; r.angle = 16'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  // Every table word is written before any command reads it.
  task automatic test_load_tables();
    for (int w = 0; w < WHEELS; w++)
      for (int s = 0; s < 15; s++)
        send_beat(load_req(w, s, rand_param(s)));
    send_beat(load_req(0, SEL_JIT, 0));
    send_beat(load_req(1, SEL_LIMIT, 32'h0100_0000));
    send_beat(load_req(1, SEL_DEAD, 32'h0010_0000));
    send_beat(load_req(1, SEL_FRIC, 32'h0008_0000));
    send_beat(load_req(2, SEL_JIT, 1));
    send_beat(load_req(2, SEL_LIMIT, 32'h7FFF_FFFF));
    send_beat(load_req(3, SEL_NONE, 32'hFFFF_FFFF));
  endtask

  task automatic test_directed();
    wheel_req_t r;
    logic [31:0] torques[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0200_0000,
                                32'h0008_0000, 32'hFFF8_0000};
    logic [31:0] speeds[5] = '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000};
    logic [15:0] angles[5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    for (int i = 0; i < 20; i++) begin
      r = rand_command();
      r.wheel = 4'(i % 4);
      r.torque = torques[i % 6];
      r.speed = speeds[i % 5];
      r.angle = angles[(i / 5) % 5];
      r.last = (i % 7) == 6;
      send_beat(r);
    end
  endtask

  // Hold off the output while items keep coming, so the input must stall.
  task automatic test_backpressure();
    wheel_req_t r;
    hold_out = 1;
    for (int i = 0; i < 8; i++) begin
      r = rand_command();
      r.last = (i == 7);
      send_beat(r);
    end
  endtask

  task automatic test_random();
    wheel_req_t r;
    for (int i = 0; i < 750; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = load_req($urandom_range(0, WHEELS - 1), $urandom_range(0, 15), 0);
        r.value = rand_param(r.sel);
      end else begin
        r = rand_command();
      end
      send_beat(r);
    end
  endtask

  initial begin
    int on_len, off_len;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end
      off_len = $urandom_range(0, 3) == 0 ? 0 : pick_gap();
      on_len = $urandom_range(0, 4) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 8);
      if (off_len > 0) begin
        out_ready <= 0;
        repeat (off_len) @(posedge clk);
      end
      out_ready <= 1;
      repeat (on_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    wheel_res_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{out_wheel, is_total, motor_torque, force_x, force_y, force_z,
              jitter_torque_x, jitter_torque_y, jitter_torque_z, last_of_run};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("** wheel_torque_and_imbalance_model_unit: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < 3; i++) begin pass_force[i] = 0; pass_torque[i] = 0; end
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_load_tables();
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("** wheel_torque_and_imbalance_model_unit: PASSED **");
    else
      $display("** wheel_torque_and_imbalance_model_unit: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
src/wtim_pkg.sv
src/wtim_ram.sv
src/wtim_mul.sv
src/wheel_torque_and_imbalance_model_unit.sv
verif/testbench.sv
